FILE: src/pladsr_pkg.sv
// shared types and constants of the polyphonic linear adsr envelope unit
package pladsr_pkg;

  localparam int unsigned LEVEL_FRAC_BITS = 16;
  localparam int unsigned LEVEL_W         = LEVEL_FRAC_BITS + 1;
  localparam int unsigned KEY_W           = 7;
  localparam int unsigned VEL_W           = 7;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 17;

  localparam logic [LEVEL_W-1:0] FULL_SCALE = LEVEL_W'(1) << LEVEL_FRAC_BITS;

  typedef logic [LEVEL_W-1:0] level_t;

  typedef enum logic [1:0] {
    CMD_PRESS   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_READ    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    MODE_NO_PERC   = 2'd0,
    MODE_DECAY     = 2'd1,
    MODE_DECAY_REL = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK_STEP   = 3'd0,
    REG_DECAY_STEP    = 3'd1,
    REG_RELEASE_STEP  = 3'd2,
    REG_SUSTAIN       = 3'd3,
    REG_ENV_MODE      = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_SWEEP,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [VEL_W-1:0] vel;
    phase_e           phase;
    level_t           level;
  } key_entry_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic clr_we;
    logic rd_en;
    logic rd_sweep;
    logic upd;
    logic load_out;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

FILE: src/pladsr_ctrl.sv
// controller state machine: clearing pass, request sequencing and key sweep
module pladsr_ctrl #(
  parameter int unsigned NUM_KEYS = 128,
  parameter int unsigned ADDR_W   = 7
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             cmd_i,
  input  pladsr_pkg::stat_t      stat_i,
  output pladsr_pkg::ctrl_t      ctrl_o,
  output logic [ADDR_W-1:0]      cnt_o
);

  localparam logic [ADDR_W-1:0] LAST_KEY = ADDR_W'(NUM_KEYS - 1);

  pladsr_pkg::state_e state_q, state_d;
  logic [ADDR_W-1:0]  cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pladsr_pkg::ST_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      pladsr_pkg::ST_CLEAR: begin
        cnt_d = cnt_q + ADDR_W'(1);
        if (cnt_q == LAST_KEY) begin
          state_d = pladsr_pkg::ST_IDLE;
          cnt_d   = '0;
        end
      end
      pladsr_pkg::ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          if (cmd_i == pladsr_pkg::CMD_TICK) begin
            state_d = pladsr_pkg::ST_SWEEP;
          end else begin
            state_d = pladsr_pkg::ST_READ;
          end
        end
      end
      pladsr_pkg::ST_READ:   state_d = pladsr_pkg::ST_UPDATE;
      pladsr_pkg::ST_UPDATE: state_d = pladsr_pkg::ST_FINISH;
      pladsr_pkg::ST_SWEEP: begin
        cnt_d = cnt_q + ADDR_W'(1);
        if (cnt_q == LAST_KEY) begin
          state_d = pladsr_pkg::ST_DRAIN;
          cnt_d   = '0;
        end
      end
      pladsr_pkg::ST_DRAIN:  state_d = pladsr_pkg::ST_FINISH;
      pladsr_pkg::ST_FINISH: begin
        if (stat_i.out_free) begin
          state_d = pladsr_pkg::ST_IDLE;
        end
      end
      default: state_d = pladsr_pkg::ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      pladsr_pkg::ST_CLEAR: ctrl_o.clr_we = 1'b1;
      pladsr_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        ctrl_o.accept = in_valid_i;
      end
      pladsr_pkg::ST_READ:   ctrl_o.rd_en = 1'b1;
      pladsr_pkg::ST_UPDATE: ctrl_o.upd = 1'b1;
      pladsr_pkg::ST_SWEEP: begin
        ctrl_o.rd_en    = 1'b1;
        ctrl_o.rd_sweep = 1'b1;
      end
      pladsr_pkg::ST_FINISH: ctrl_o.load_out = stat_i.out_free;
      default: ;
    endcase
  end

  assign cnt_o = cnt_q;

endmodule

FILE: src/pladsr_dp.sv
// datapath: key state memory, configuration registers, envelope step and output register
module pladsr_dp #(
  parameter int unsigned NUM_KEYS = 128,
  parameter int unsigned ADDR_W   = 7
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pladsr_pkg::ctrl_t                    ctrl_i,
  input  logic [ADDR_W-1:0]                    cnt_i,
  output pladsr_pkg::stat_t                    stat_o,
  input  logic [1:0]                           cmd_i,
  input  logic [pladsr_pkg::KEY_W-1:0]         key_number_i,
  input  logic [pladsr_pkg::VEL_W-1:0]         key_velocity_i,
  input  logic                                 cfg_valid_i,
  input  logic [pladsr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pladsr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [pladsr_pkg::KEY_W-1:0]         out_key_o,
  output logic [pladsr_pkg::LEVEL_W-1:0]       out_level_o,
  output logic [2:0]                           out_phase_o,
  output logic [pladsr_pkg::VEL_W-1:0]         out_velocity_o
);

  // configuration registers
  pladsr_pkg::level_t attack_q, decay_q, release_q, sustain_q;
  logic [1:0]         mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= pladsr_pkg::FULL_SCALE;
      decay_q   <= '0;
      release_q <= pladsr_pkg::FULL_SCALE;
      sustain_q <= pladsr_pkg::FULL_SCALE;
      mode_q    <= pladsr_pkg::MODE_NO_PERC;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pladsr_pkg::REG_ATTACK_STEP:   attack_q  <= cfg_data_i;
        pladsr_pkg::REG_DECAY_STEP:    decay_q   <= cfg_data_i;
        pladsr_pkg::REG_RELEASE_STEP:  release_q <= cfg_data_i;
        pladsr_pkg::REG_SUSTAIN:       sustain_q <= cfg_data_i;
        pladsr_pkg::REG_ENV_MODE:      mode_q    <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // latched request
  logic [1:0]                   cmd_q;
  logic [pladsr_pkg::KEY_W-1:0] key_q;
  logic [pladsr_pkg::VEL_W-1:0] vel_q;
  logic                         key_valid;
  logic [ADDR_W-1:0]            key_addr;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      cmd_q <= cmd_i;
      key_q <= key_number_i;
      vel_q <= key_velocity_i;
    end
  end

  assign key_valid = 32'(key_q) < NUM_KEYS;
  assign key_addr  = ADDR_W'(key_q);

  // key state memory
  pladsr_pkg::key_entry_t mem_q [NUM_KEYS];
  pladsr_pkg::key_entry_t rdata_q;
  pladsr_pkg::key_entry_t wdata;
  logic                   we;
  logic [ADDR_W-1:0]      waddr;
  logic [ADDR_W-1:0]      raddr;

  assign raddr = ctrl_i.rd_sweep ? cnt_i : key_addr;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // sweep writeback stage
  logic              proc_vld_q;
  logic [ADDR_W-1:0] proc_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_vld_q <= 1'b0;
    end else begin
      proc_vld_q <= ctrl_i.rd_en && ctrl_i.rd_sweep;
    end
  end

  always_ff @(posedge clk_i) begin
    proc_addr_q <= cnt_i;
  end

  // one envelope step
  pladsr_pkg::level_t             sus;
  pladsr_pkg::level_t             thres;
  pladsr_pkg::phase_e             after;
  logic [pladsr_pkg::LEVEL_W:0]   sum;
  pladsr_pkg::key_entry_t         adv;

  always_comb begin
    sus = (sustain_q > pladsr_pkg::FULL_SCALE) ? pladsr_pkg::FULL_SCALE : sustain_q;
    if (mode_q == pladsr_pkg::MODE_NO_PERC) begin
      thres = sus;
      after = pladsr_pkg::PH_SUSTAIN;
    end else if (mode_q == pladsr_pkg::MODE_DECAY_REL) begin
      thres = sus;
      after = pladsr_pkg::PH_RELEASE;
    end else begin
      thres = '0;
      after = pladsr_pkg::PH_IDLE;
    end
    sum = {1'b0, rdata_q.level} + {1'b0, attack_q};
    adv = rdata_q;
    case (rdata_q.phase)
      pladsr_pkg::PH_ATTACK: begin
        if (sum >= {1'b0, pladsr_pkg::FULL_SCALE}) begin
          adv.level = pladsr_pkg::FULL_SCALE;
          adv.phase = pladsr_pkg::PH_DECAY;
        end else begin
          adv.level = sum[pladsr_pkg::LEVEL_W-1:0];
        end
      end
      pladsr_pkg::PH_DECAY: begin
        if (decay_q == '0) begin
          adv.phase = after;
        end else if (rdata_q.level <= thres || (rdata_q.level - thres) <= decay_q) begin
          adv.level = thres;
          adv.phase = after;
        end else begin
          adv.level = rdata_q.level - decay_q;
        end
      end
      pladsr_pkg::PH_RELEASE: begin
        if (rdata_q.level <= release_q) begin
          adv.level = '0;
          adv.phase = pladsr_pkg::PH_IDLE;
        end else begin
          adv.level = rdata_q.level - release_q;
        end
      end
      default: ;
    endcase
  end

  // press and release update
  pladsr_pkg::key_entry_t upd;
  logic                   upd_we;

  always_comb begin
    upd    = rdata_q;
    upd_we = 1'b0;
    case (cmd_q)
      pladsr_pkg::CMD_PRESS: begin
        if (key_valid) begin
          upd.vel   = vel_q;
          upd.phase = pladsr_pkg::PH_ATTACK;
          upd_we    = 1'b1;
        end
      end
      pladsr_pkg::CMD_RELEASE: begin
        if (key_valid && mode_q == pladsr_pkg::MODE_NO_PERC) begin
          upd.vel   = vel_q;
          upd.phase = pladsr_pkg::PH_RELEASE;
          upd_we    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // write port select
  always_comb begin
    we    = 1'b0;
    waddr = cnt_i;
    wdata = '0;
    if (ctrl_i.clr_we) begin
      we = 1'b1;
    end else if (ctrl_i.upd) begin
      we    = upd_we;
      waddr = key_addr;
      wdata = upd;
    end else if (proc_vld_q) begin
      we    = 1'b1;
      waddr = proc_addr_q;
      wdata = adv;
    end
  end

  // result of the addressed key
  pladsr_pkg::key_entry_t res_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.upd) begin
      res_q <= upd;
    end else if (proc_vld_q && proc_addr_q == key_addr) begin
      res_q <= adv;
    end
  end

  // output register
  logic                         out_valid_q;
  logic [pladsr_pkg::KEY_W-1:0] out_key_q;
  pladsr_pkg::key_entry_t       out_ent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_out) begin
      out_key_q <= key_q;
      out_ent_q <= key_valid ? res_q : '0;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_key_o       = out_key_q;
  assign out_level_o     = out_ent_q.level;
  assign out_phase_o     = out_ent_q.phase;
  assign out_velocity_o  = out_ent_q.vel;

endmodule

FILE: src/polyphonic_linear_adsr_envelope_unit.sv
// top level of the polyphonic linear adsr envelope unit
//
// Usage: requests enter on the in channel (cmd, key number, velocity) and
// every request gives exactly one result on the out channel (key, level,
// phase, velocity of the addressed key after the request). The cfg channel
// writes the step, sustain and mode registers; it is always ready. The
// user must write it only while no request is in flight; the block
// itself does not enforce this. One request is worked on at a time.
// A press, release or read reads the key memory, updates the key and
// writes it back, then loads the output register; the next request is
// accepted after that. A tick walks all NUM_KEYS keys through the key
// memory, reading one key while writing back the one before; a drain
// step writes back the last key, and the result of the addressed key
// is then loaded into the output register.
// The output register holds a result while the receiver stalls; the next
// request is accepted meanwhile and finishes up to the point of loading
// that register.
// After reset the key memory is cleared, one key per cycle, for all
// NUM_KEYS keys; no request is accepted during that pass.
module polyphonic_linear_adsr_envelope_unit #(
  parameter int unsigned NUM_KEYS = 128
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [1:0]                           cmd_i,
  input  logic [pladsr_pkg::KEY_W-1:0]         key_number_i,
  input  logic [pladsr_pkg::VEL_W-1:0]         key_velocity_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pladsr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pladsr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [pladsr_pkg::KEY_W-1:0]         out_key_o,
  output logic [pladsr_pkg::LEVEL_W-1:0]       out_level_o,
  output logic [2:0]                           out_phase_o,
  output logic [pladsr_pkg::VEL_W-1:0]         out_velocity_o
);

  localparam int unsigned ADDR_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  pladsr_pkg::ctrl_t ctrl;
  pladsr_pkg::stat_t stat;
  logic [ADDR_W-1:0] cnt;

  assign cfg_ready_o = 1'b1;

  pladsr_ctrl #(
    .NUM_KEYS (NUM_KEYS),
    .ADDR_W   (ADDR_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .cnt_o      (cnt)
  );

  pladsr_dp #(
    .NUM_KEYS (NUM_KEYS),
    .ADDR_W   (ADDR_W)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .cnt_i          (cnt),
    .stat_o         (stat),
    .cmd_i          (cmd_i),
    .key_number_i   (key_number_i),
    .key_velocity_i (key_velocity_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_key_o      (out_key_o),
    .out_level_o    (out_level_o),
    .out_phase_o    (out_phase_o),
    .out_velocity_o (out_velocity_o)
  );

  // one request in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  // levels never exceed full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_level_o <= pladsr_pkg::FULL_SCALE)
    else $error("level above full scale");

  // a stalled result holds still
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_key_o) &&
    $stable(out_level_o) && $stable(out_phase_o) && $stable(out_velocity_o))
    else $error("result changed while stalled");

  // phase code stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_phase_o <= pladsr_pkg::PH_RELEASE)
    else $error("phase code out of range");

endmodule

FILE: verif/testbench.sv
// self-checking testbench of the polyphonic linear adsr envelope unit
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_KEYS       = 128;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned SETTLE_CYCLES  = 12;
  localparam int unsigned RANDOM_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS    = 150;
  localparam logic [1:0]  MODE_THREE     = 2'd3;

  typedef struct {
    logic [pladsr_pkg::KEY_W-1:0] key;
    pladsr_pkg::level_t           level;
    pladsr_pkg::phase_e           phase;
    logic [pladsr_pkg::VEL_W-1:0] vel;
  } key_report_t;

  logic                              clk_i          = 1'b0;
  logic                              rst_ni         = 1'b0;
  logic                              in_valid_i     = 1'b0;
  logic                              in_ready_o;
  logic [1:0]                        cmd_i          = pladsr_pkg::CMD_READ;
  logic [pladsr_pkg::KEY_W-1:0]      key_number_i   = '0;
  logic [pladsr_pkg::VEL_W-1:0]      key_velocity_i = '0;
  logic                              cfg_valid_i    = 1'b0;
  logic                              cfg_ready_o;
  logic [pladsr_pkg::CFG_IDX_W-1:0]  cfg_index_i    = pladsr_pkg::REG_ATTACK_STEP;
  logic [pladsr_pkg::CFG_DATA_W-1:0] cfg_data_i     = '0;
  logic                              out_valid_o;
  logic                              out_ready_i    = 1'b0;
  logic [pladsr_pkg::KEY_W-1:0]      out_key_o;
  logic [pladsr_pkg::LEVEL_W-1:0]    out_level_o;
  logic [2:0]                        out_phase_o;
  logic [pladsr_pkg::VEL_W-1:0]      out_velocity_o;

  // envelope state and register copies
  pladsr_pkg::phase_e           key_ph  [NUM_KEYS];
  pladsr_pkg::level_t           key_lvl [NUM_KEYS];
  logic [pladsr_pkg::VEL_W-1:0] key_vel [NUM_KEYS];
  pladsr_pkg::level_t           attack_step, decay_step, release_step, sustain_target;
  logic [1:0]                   env_mode;

  key_report_t                  expected_reports[$];
  int unsigned                  error_count = 0;
  int unsigned                  burst_left  = 0;
  int unsigned                  idle_cycles = 0;
  bit                           long_hold_req = 1'b0;
  int unsigned                  hold_left = 0;
  int unsigned                  pattern_left = 0;
  int unsigned                  stall_pct = 0;
  logic [pladsr_pkg::KEY_W-1:0] key_pool[6];

  polyphonic_linear_adsr_envelope_unit #(
    .NUM_KEYS(NUM_KEYS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .key_number_i   (key_number_i),
    .key_velocity_i (key_velocity_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_key_o      (out_key_o),
    .out_level_o    (out_level_o),
    .out_phase_o    (out_phase_o),
    .out_velocity_o (out_velocity_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void clear_envelopes();
    attack_step    = pladsr_pkg::FULL_SCALE;
    decay_step     = '0;
    release_step   = pladsr_pkg::FULL_SCALE;
    sustain_target = pladsr_pkg::FULL_SCALE;
    env_mode       = pladsr_pkg::MODE_NO_PERC;
    for (int k = 0; k < NUM_KEYS; k++) begin
      key_ph[k]  = pladsr_pkg::PH_IDLE;
      key_lvl[k] = '0;
      key_vel[k] = '0;
    end
  endfunction

  function automatic void tick_all_keys();
    pladsr_pkg::level_t               sus;
    pladsr_pkg::level_t               target;
    pladsr_pkg::phase_e               after;
    logic [pladsr_pkg::LEVEL_W+1:0]   sum;
    pladsr_pkg::level_t               lv;
    sus = (sustain_target > pladsr_pkg::FULL_SCALE) ? pladsr_pkg::FULL_SCALE
                                                     : sustain_target;
    if (env_mode == pladsr_pkg::MODE_NO_PERC) begin
      target = sus;
      after  = pladsr_pkg::PH_SUSTAIN;
    end else if (env_mode == pladsr_pkg::MODE_DECAY_REL) begin
      target = sus;
      after  = pladsr_pkg::PH_RELEASE;
    end else begin
      target = '0;
      after  = pladsr_pkg::PH_IDLE;
    end
    for (int k = 0; k < NUM_KEYS; k++) begin
      lv = key_lvl[k];
      case (key_ph[k])
        pladsr_pkg::PH_ATTACK: begin
          sum = {2'b00, lv} + {2'b00, attack_step};
          if (sum >= {2'b00, pladsr_pkg::FULL_SCALE}) begin
            lv        = pladsr_pkg::FULL_SCALE;
            key_ph[k] = pladsr_pkg::PH_DECAY;
          end else begin
            lv = sum[pladsr_pkg::LEVEL_W-1:0];
          end
        end
        pladsr_pkg::PH_DECAY: begin
          if (decay_step == '0) begin
            key_ph[k] = after;
          end else if (lv <= target || (lv - target) <= decay_step) begin
            lv        = target;
            key_ph[k] = after;
          end else begin
            lv = lv - decay_step;
          end
        end
        pladsr_pkg::PH_RELEASE: begin
          if (lv <= release_step) begin
            lv        = '0;
            key_ph[k] = pladsr_pkg::PH_IDLE;
          end else begin
            lv = lv - release_step;
          end
        end
        default: ;
      endcase
      key_lvl[k] = lv;
    end
  endfunction

  function automatic key_report_t envelope_predict(pladsr_pkg::cmd_e cmd,
                                                   logic [pladsr_pkg::KEY_W-1:0] key,
                                                   logic [pladsr_pkg::VEL_W-1:0] vel);
    key_report_t rep;
    case (cmd)
      pladsr_pkg::CMD_PRESS: begin
        key_vel[key] = vel;
        key_ph[key]  = pladsr_pkg::PH_ATTACK;
      end
      pladsr_pkg::CMD_RELEASE: begin
        if (env_mode == pladsr_pkg::MODE_NO_PERC) begin
          key_vel[key] = vel;
          key_ph[key]  = pladsr_pkg::PH_RELEASE;
        end
      end
      pladsr_pkg::CMD_TICK: tick_all_keys();
      default: ;
    endcase
    rep.key   = key;
    rep.level = key_lvl[key];
    rep.phase = key_ph[key];
    rep.vel   = key_vel[key];
    return rep;
  endfunction

  task automatic send_request(pladsr_pkg::cmd_e cmd, logic [pladsr_pkg::KEY_W-1:0] key,
                              logic [pladsr_pkg::VEL_W-1:0] vel);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    cmd_i          <= cmd;
    key_number_i   <= key;
    key_velocity_i <= vel;
    do @(posedge clk_i); while (!in_ready_o);
    expected_reports.push_back(envelope_predict(cmd, key, vel));
  endtask

  // wait until every result is back and the block has gone quiet
  task automatic settle_block();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(pladsr_pkg::reg_idx_e idx,
                           logic [pladsr_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      pladsr_pkg::REG_ATTACK_STEP:  attack_step    = data;
      pladsr_pkg::REG_DECAY_STEP:   decay_step     = data;
      pladsr_pkg::REG_RELEASE_STEP: release_step   = data;
      pladsr_pkg::REG_SUSTAIN:      sustain_target = data;
      pladsr_pkg::REG_ENV_MODE:     env_mode       = data[1:0];
      default: ;
    endcase
  endtask

  task automatic program_envelope(pladsr_pkg::level_t atk, pladsr_pkg::level_t dec,
                                  pladsr_pkg::level_t rel, pladsr_pkg::level_t sus,
                                  logic [1:0] mode);
    write_reg(pladsr_pkg::REG_ATTACK_STEP, atk);
    write_reg(pladsr_pkg::REG_DECAY_STEP, dec);
    write_reg(pladsr_pkg::REG_RELEASE_STEP, rel);
    write_reg(pladsr_pkg::REG_SUSTAIN, sus);
    write_reg(pladsr_pkg::REG_ENV_MODE, {{(pladsr_pkg::CFG_DATA_W-2){1'b0}}, mode});
    cfg_valid_i <= 1'b0;
  endtask

  function automatic pladsr_pkg::level_t pick_step();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return pladsr_pkg::FULL_SCALE;
      3:       return pladsr_pkg::level_t'($urandom_range(0, 131071));
      default: return pladsr_pkg::level_t'($urandom_range(1000, 30000));
    endcase
  endfunction

  function automatic pladsr_pkg::level_t pick_sustain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return pladsr_pkg::FULL_SCALE;
      default: return pladsr_pkg::level_t'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic test_default_envelope();
    send_request(pladsr_pkg::CMD_READ, 7'd0, 7'd0);
    send_request(pladsr_pkg::CMD_PRESS, 7'd0, 7'h7f);
    send_request(pladsr_pkg::CMD_TICK, 7'd0, 7'd0);
    send_request(pladsr_pkg::CMD_TICK, 7'd0, 7'h7f);
    send_request(pladsr_pkg::CMD_RELEASE, 7'd0, 7'd0);
    send_request(pladsr_pkg::CMD_TICK, 7'd0, 7'd0);
    send_request(pladsr_pkg::CMD_PRESS, 7'd127, 7'h55);
    send_request(pladsr_pkg::CMD_READ, 7'd127, 7'h2a);
    send_request(pladsr_pkg::CMD_TICK, 7'd127, 7'd0);
    send_request(pladsr_pkg::CMD_RELEASE, 7'd127, 7'h2a);
    // retrigger from a nonzero level
    send_request(pladsr_pkg::CMD_PRESS, 7'd127, 7'h7f);
    settle_block();
  endtask

  task automatic test_step_clamps();
    program_envelope('1, pladsr_pkg::FULL_SCALE, '0, '1, pladsr_pkg::MODE_DECAY_REL);
    send_request(pladsr_pkg::CMD_PRESS, 7'd5, 7'd1);
    send_request(pladsr_pkg::CMD_TICK, 7'd5, 7'd0);
    send_request(pladsr_pkg::CMD_TICK, 7'd5, 7'd0);
    // zero release step holds the level
    send_request(pladsr_pkg::CMD_TICK, 7'd5, 7'd0);
    send_request(pladsr_pkg::CMD_RELEASE, 7'd5, 7'd9);
    settle_block();
  endtask

  task automatic test_decay_below_target();
    program_envelope(pladsr_pkg::FULL_SCALE, 17'd30000, pladsr_pkg::FULL_SCALE, '0,
                     pladsr_pkg::MODE_NO_PERC);
    send_request(pladsr_pkg::CMD_PRESS, 7'd9, 7'd33);
    send_request(pladsr_pkg::CMD_TICK, 7'd9, 7'd0);
    send_request(pladsr_pkg::CMD_TICK, 7'd9, 7'd0);
    settle_block();
    program_envelope(pladsr_pkg::FULL_SCALE, 17'd30000, pladsr_pkg::FULL_SCALE, '1,
                     pladsr_pkg::MODE_NO_PERC);
    send_request(pladsr_pkg::CMD_TICK, 7'd9, 7'd0);
    settle_block();
  endtask

  task automatic test_mode_three();
    program_envelope('0, pladsr_pkg::FULL_SCALE, pladsr_pkg::FULL_SCALE, '0, MODE_THREE);
    send_request(pladsr_pkg::CMD_PRESS, 7'd12, 7'd100);
    send_request(pladsr_pkg::CMD_TICK, 7'd12, 7'd0);
    send_request(pladsr_pkg::CMD_RELEASE, 7'd12, 7'd3);
    settle_block();
    program_envelope(pladsr_pkg::FULL_SCALE, pladsr_pkg::FULL_SCALE,
                     pladsr_pkg::FULL_SCALE, '0, MODE_THREE);
    send_request(pladsr_pkg::CMD_TICK, 7'd12, 7'd0);
    send_request(pladsr_pkg::CMD_TICK, 7'd12, 7'd0);
    settle_block();
  endtask

  task automatic play_random_phrase(int unsigned n_items);
    pladsr_pkg::cmd_e             cmd;
    logic [pladsr_pkg::KEY_W-1:0] key;
    int unsigned                  r;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 22)      cmd = pladsr_pkg::CMD_PRESS;
      else if (r < 34) cmd = pladsr_pkg::CMD_RELEASE;
      else if (r < 78) cmd = pladsr_pkg::CMD_TICK;
      else             cmd = pladsr_pkg::CMD_READ;
      key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 5)]
                                       : pladsr_pkg::KEY_W'($urandom);
      send_request(cmd, key, pladsr_pkg::VEL_W'($urandom));
    end
  endtask

  task automatic test_random_envelopes();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      program_envelope(pick_step(), pick_step(), pick_step(), pick_sustain(),
                       2'($urandom_range(0, 3)));
      foreach (key_pool[i]) key_pool[i] = pladsr_pkg::KEY_W'($urandom);
      key_pool[0] = (p % 2 == 0) ? 7'd0 : 7'd127;
      if (p == 3) long_hold_req = 1'b1;
      play_random_phrase(PHASE_ITEMS);
      settle_block();
    end
  endtask

  initial begin
    clear_envelopes();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_default_envelope();
    test_step_clamps();
    test_decay_below_target();
    test_mode_three();
    test_random_envelopes();
    settle_block();
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // receiver stall pattern with one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD;
      out_ready_i <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(10, 80);
        case ($urandom_range(0, 3))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 30;
          default: stall_pct = 70;
        endcase
      end
      pattern_left--;
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    key_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_reports.size() == 0) begin
        $error("result for key %0d with no request pending", out_key_o);
        error_count++;
      end else begin
        want = expected_reports.pop_front();
        if (out_key_o !== want.key) begin
          $error("out_key expected %0d got %0d", want.key, out_key_o);
          error_count++;
        end
        if (out_level_o !== want.level) begin
          $error("out_level expected %0d got %0d", want.level, out_level_o);
          error_count++;
        end
        if (out_phase_o !== want.phase) begin
          $error("out_phase expected %0d got %0d", want.phase, out_phase_o);
          error_count++;
        end
        if (out_velocity_o !== want.vel) begin
          $error("out_velocity expected %0d got %0d", want.vel, out_velocity_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
